// ----- rtl/core/mbe_pkg.sv -----
// Package with shared constants and types for the escape-time pixel core.
`timescale 1ns / 1ps

package mbe_pkg;

  // Default values of the core parameters.
  localparam int unsigned COORD_BITS_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 28;
  localparam int unsigned ITER_BITS_DEF  = 12;
  localparam int unsigned DIM_BITS_DEF   = 12;

  // Fixed field and register widths.
  localparam int unsigned PIX_W      = 12;
  localparam int unsigned COUNT_W    = 12;
  localparam int unsigned GREEN_W    = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CENTER_W   = 32;
  localparam int unsigned SCALE_W    = 30;
  localparam int unsigned DIMREG_W   = 13;
  localparam int unsigned MAXIT_W    = 12;
  // Three times the scale needs two more bits than the scale itself.
  localparam int unsigned SPAN_W     = SCALE_W + 2;
  // Divisors are image sizes or the iteration limit, all below 2^13.
  localparam int unsigned DSR_W      = 13;
  localparam int unsigned GREEN_MAX  = 255;

  // Register reset values.
  localparam logic [CENTER_W-1:0] CENTER_RE_RST = 32'hF800_0000;
  localparam logic [CENTER_W-1:0] CENTER_IM_RST = 32'h0000_0000;
  localparam logic [SCALE_W-1:0]  SCALE_RST     = 30'h1000_0000;
  localparam logic [DIMREG_W-1:0] WIDTH_RST     = 13'd640;
  localparam logic [DIMREG_W-1:0] HEIGHT_RST    = 13'd480;
  localparam logic [MAXIT_W-1:0]  MAXIT_RST     = 12'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_RE = 3'd0,
    CFG_CENTER_IM = 3'd1,
    CFG_SCALE     = 3'd2,
    CFG_WIDTH     = 3'd3,
    CFG_HEIGHT    = 3'd4,
    CFG_MAXIT     = 3'd5
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MAP   = 5'b00010,
    ST_ITER  = 5'b00100,
    ST_GREEN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

// ----- rtl/core/mbe_if.sv -----
// Handshake channels for pixel words in and result words out.
`timescale 1ns / 1ps

interface mbe_pix_if
  import mbe_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mbe_res_if
  import mbe_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] iteration_count;
  logic [GREEN_W-1:0] green_level;
  logic               in_set;

  modport source (output valid, output iteration_count, output green_level,
                  output in_set, input ready);
  modport sink   (input valid, input iteration_count, input green_level,
                  input in_set, output ready);
endinterface

// ----- rtl/core/mbe_div_cell.sv -----
// One restoring division cell: develops one quotient bit and passes the word on.
`timescale 1ns / 1ps

module mbe_div_cell
  import mbe_pkg::*;
#(
  parameter int unsigned DVD_W = 44
) (
  input  logic                   clk_i,
  input  logic [DSR_W+DVD_W-1:0] word_i,
  input  logic [DSR_W-1:0]       dsr_i,
  output logic [DSR_W+DVD_W-1:0] word_o,
  output logic [DSR_W-1:0]       dsr_o
);

  // The word holds the partial remainder on top and the dividend bits below;
  // quotient bits enter from the bottom as dividend bits leave the top.
  logic [DSR_W-1:0]       rem;
  logic [DVD_W-1:0]       dvd;
  logic [DSR_W:0]         cand;
  logic [DSR_W:0]         diff;
  logic                   qbit;
  logic [DSR_W+DVD_W-1:0] word_d;
  logic [DSR_W+DVD_W-1:0] word_q;
  logic [DSR_W-1:0]       dsr_q;

  always_comb begin
    rem    = word_i[DSR_W+DVD_W-1:DVD_W];
    dvd    = word_i[DVD_W-1:0];
    cand   = {rem, dvd[DVD_W-1]};
    diff   = cand - {1'b0, dsr_i};
    qbit   = (cand >= {1'b0, dsr_i});
    word_d = qbit ? {diff[DSR_W-1:0], dvd[DVD_W-2:0], 1'b1}
                  : {cand[DSR_W-1:0], dvd[DVD_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    dsr_q  <= dsr_i;
  end

  assign word_o = word_q;
  assign dsr_o  = dsr_q;

endmodule

// ----- rtl/core/mbe_z_step.sv -----
// One escape-time step: escape test on |z|^2 and the saturated z*z + c update.
`timescale 1ns / 1ps

module mbe_z_step
  import mbe_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] zr_i,
  input  logic signed [COORD_BITS-1:0] zi_i,
  input  logic signed [COORD_BITS-1:0] cr_i,
  input  logic signed [COORD_BITS-1:0] ci_i,
  output logic signed [COORD_BITS-1:0] zr_o,
  output logic signed [COORD_BITS-1:0] zi_o,
  output logic                         esc_o
);

  localparam int unsigned PW = 2 * COORD_BITS;
  localparam int unsigned SW = PW + 2;
  localparam logic [PW:0] ESC_LIM = (PW + 1)'(1) << (2 * FRAC_BITS + 2);

  function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [SW-1:0] v);
    logic [SW-COORD_BITS:0] top;
    logic signed [COORD_BITS-1:0] res;
    top = v[SW-1:COORD_BITS-1];
    if ((top == '0) || (top == '1)) begin
      res = v[COORD_BITS-1:0];
    end else if (v[SW-1]) begin
      res = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return res;
  endfunction

  logic signed [PW-1:0] sq_r;
  logic signed [PW-1:0] sq_i;
  logic signed [PW-1:0] prod_ri;
  logic        [PW:0]   mag_sum;
  logic signed [PW:0]   diff;
  logic signed [PW:0]   dbl;
  logic signed [PW:0]   sh_r;
  logic signed [PW:0]   sh_i;
  logic signed [SW-1:0] sum_r;
  logic signed [SW-1:0] sum_i;

  always_comb begin
    sq_r    = zr_i * zr_i;
    sq_i    = zi_i * zi_i;
    prod_ri = zr_i * zi_i;
    // Both squares are non-negative, so their sum is taken unsigned.
    mag_sum = (PW + 1)'($unsigned(sq_r)) + (PW + 1)'($unsigned(sq_i));
    esc_o   = (mag_sum >= ESC_LIM);
    diff    = (PW + 1)'(sq_r) - (PW + 1)'(sq_i);
    dbl     = (PW + 1)'(prod_ri) <<< 1;
    sh_r    = diff >>> FRAC_BITS;
    sh_i    = dbl >>> FRAC_BITS;
    sum_r   = SW'(sh_r) + SW'(cr_i);
    sum_i   = SW'(sh_i) + SW'(ci_i);
    zr_o    = sat(sum_r);
    zi_o    = sat(sum_i);
  end

endmodule

// ----- rtl/core/mandelbrot_escape_pixel_core.sv -----
// Top level of the escape-time pixel core: mapping, iteration and colour level.
//
//  Channel   Direction  Contents                                    Handshake
//  pix_i     in         pixel_x, pixel_y                            valid/ready
//  res_o     out        iteration_count, green_level, in_set        valid/ready
//  cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i             write enable
//
// The divider chain has DIM_BITS + 32 cells. The two coordinate divisions share the
// chain, the imaginary one entering in the cycle after the real one; the iteration
// step runs once a cycle, and the colour division takes one more pass down the
// chain. One pixel is worked on at a time; the next is taken as soon as its result
// sits in the output register. Reset is asynchronous and active low; a stalled
// result word holds until taken.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_core
  import mbe_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF,
  parameter int unsigned ITER_BITS  = ITER_BITS_DEF,
  parameter int unsigned DIM_BITS   = DIM_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mbe_pix_if.sink               pix_i,
  mbe_res_if.source             res_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DVD_W = DIM_BITS + SPAN_W;
  localparam int unsigned WW    = DSR_W + DVD_W;
  localparam int unsigned MW    = ((DVD_W > COORD_BITS) ? DVD_W : COORD_BITS) + 2;
  localparam int unsigned CNT_W = $clog2(DVD_W + 2);
  localparam int unsigned GD_W  = ITER_BITS + GREEN_W;

  function automatic logic signed [COORD_BITS-1:0] sat_map(input logic signed [MW-1:0] v);
    logic [MW-COORD_BITS:0] top;
    logic signed [COORD_BITS-1:0] res;
    top = v[MW-1:COORD_BITS-1];
    if ((top == '0) || (top == '1)) begin
      res = v[COORD_BITS-1:0];
    end else if (v[MW-1]) begin
      res = {1'b1, {(COORD_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_BITS-1){1'b1}}};
    end
    return res;
  endfunction

  // Configuration registers.
  logic [CENTER_W-1:0] center_re_q, center_im_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [DIMREG_W-1:0] width_q, height_q;
  logic [MAXIT_W-1:0]  maxit_reg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_re_q <= CENTER_RE_RST;
      center_im_q <= CENTER_IM_RST;
      scale_q     <= SCALE_RST;
      width_q     <= WIDTH_RST;
      height_q    <= HEIGHT_RST;
      maxit_reg_q <= MAXIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_CENTER_RE: center_re_q <= cfg_data_i[CENTER_W-1:0];
        CFG_CENTER_IM: center_im_q <= cfg_data_i[CENTER_W-1:0];
        CFG_SCALE:     scale_q     <= cfg_data_i[SCALE_W-1:0];
        CFG_WIDTH:     width_q     <= cfg_data_i[DIMREG_W-1:0];
        CFG_HEIGHT:    height_q    <= cfg_data_i[DIMREG_W-1:0];
        CFG_MAXIT:     maxit_reg_q <= cfg_data_i[MAXIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [ITER_BITS-1:0] maxit;
  logic [SPAN_W-1:0]    span_re, span_im;

  assign maxit   = ITER_BITS'(maxit_reg_q);
  assign span_re = (SPAN_W'(scale_q) << 1) + SPAN_W'(scale_q);
  assign span_im = SPAN_W'(scale_q) << 1;

  // Control and working registers.
  state_e                      state_q, state_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [DIM_BITS-1:0]         px_q, py_q;
  logic signed [COORD_BITS-1:0] cr_q, ci_q, zr_q, zi_q;
  logic [ITER_BITS-1:0]        count_q;
  logic                        out_valid_q;
  logic [COUNT_W-1:0]          out_count_q;
  logic [GREEN_W-1:0]          out_green_q;
  logic                        out_in_set_q;

  // Divider chain.
  logic [WW-1:0]    chain_word [DVD_W+1];
  logic [DSR_W-1:0] chain_dsr  [DVD_W+1];
  logic [DVD_W-1:0] quot;

  // The colour dividend stays at the chain input while the finished word waits,
  // so the quotient is still valid when the output register is loaded.
  always_comb begin
    if ((state_q == ST_GREEN) || (state_q == ST_DONE)) begin
      chain_word[0] = WW'(((GD_W)'(count_q) << GREEN_W) - (GD_W)'(count_q));
      chain_dsr[0]  = DSR_W'(maxit);
    end else if (cnt_q == CNT_W'(1)) begin
      chain_word[0] = WW'(DVD_W'(py_q) * DVD_W'(span_im));
      chain_dsr[0]  = DSR_W'(height_q);
    end else begin
      chain_word[0] = WW'(DVD_W'(px_q) * DVD_W'(span_re));
      chain_dsr[0]  = DSR_W'(width_q);
    end
  end

  for (genvar g = 0; g < DVD_W; g++) begin : g_cell
    mbe_div_cell #(
      .DVD_W (DVD_W)
    ) u_cell (
      .clk_i  (clk_i),
      .word_i (chain_word[g]),
      .dsr_i  (chain_dsr[g]),
      .word_o (chain_word[g+1]),
      .dsr_o  (chain_dsr[g+1])
    );
  end

  assign quot = chain_word[DVD_W][DVD_W-1:0];

  // Coordinate mapping from the quotient leaving the chain.
  logic signed [MW-1:0] map_center;
  logic signed [MW-1:0] map_half;
  logic signed [MW-1:0] map_off;
  logic signed [MW-1:0] map_sum;
  logic                 map_is_im;

  always_comb begin
    map_is_im = (cnt_q == CNT_W'(DVD_W + 1));
    if (map_is_im) begin
      map_center = MW'($signed(center_im_q));
      map_half   = MW'(scale_q);
      map_off    = (height_q != '0) ? MW'(quot) : '0;
    end else begin
      map_center = MW'($signed(center_re_q));
      map_half   = MW'(span_re >> 1);
      map_off    = (width_q != '0) ? MW'(quot) : '0;
    end
    map_sum = map_center - map_half + map_off;
  end

  // Iteration step.
  logic signed [COORD_BITS-1:0] zr_nx, zi_nx;
  logic                         esc;
  logic                         iter_end;
  logic                         out_free;

  mbe_z_step #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_step (
    .zr_i  (zr_q),
    .zi_i  (zi_q),
    .cr_i  (cr_q),
    .ci_i  (ci_q),
    .zr_o  (zr_nx),
    .zi_o  (zi_nx),
    .esc_o (esc)
  );

  assign iter_end = (count_q >= maxit) || esc;
  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (pix_i.valid) begin
          state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DVD_W + 1)) begin
          state_d = ST_ITER;
          cnt_d   = '0;
        end
      end
      ST_ITER: begin
        if (iter_end) begin
          state_d = ST_GREEN;
          cnt_d   = '0;
        end
      end
      ST_GREEN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DVD_W)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == ST_MAP && map_is_im) begin
        count_q <= '0;
      end else if (state_q == ST_ITER && !iter_end) begin
        count_q <= count_q + ITER_BITS'(1);
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && pix_i.valid) begin
      px_q <= DIM_BITS'(pix_i.pixel_x);
      py_q <= DIM_BITS'(pix_i.pixel_y);
    end
    if (state_q == ST_MAP && cnt_q == CNT_W'(DVD_W)) begin
      cr_q <= sat_map(map_sum);
    end
    if (state_q == ST_MAP && map_is_im) begin
      ci_q <= sat_map(map_sum);
      zr_q <= '0;
      zi_q <= '0;
    end else if (state_q == ST_ITER && !iter_end) begin
      zr_q <= zr_nx;
      zi_q <= zi_nx;
    end
    if (state_q == ST_DONE && out_free) begin
      out_count_q  <= COUNT_W'(count_q);
      out_in_set_q <= (count_q >= maxit);
      out_green_q  <= (count_q >= maxit) ? '0 : quot[GREEN_W-1:0];
    end
  end

  assign pix_i.ready           = (state_q == ST_IDLE);
  assign res_o.valid           = out_valid_q;
  assign res_o.iteration_count = out_count_q;
  assign res_o.green_level     = out_green_q;
  assign res_o.in_set          = out_in_set_q;

  // A result inside the set never carries a colour.
  a_set_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.in_set |-> res_o.green_level == '0)
    else $error("in-set result with non-zero green level");

  // The step counter never runs past the limit.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ITER |-> count_q <= maxit)
    else $error("iteration count beyond limit");

  // The colour pass ends exactly when the chain has delivered its quotient.
  a_green_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GREEN && cnt_q == CNT_W'(DVD_W) |=> state_q == ST_DONE)
    else $error("colour division left early or late");

  // A pixel is taken only when no other is in work.
  a_one_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.valid && pix_i.ready |=> state_q == ST_MAP && cnt_q == '0)
    else $error("pixel accepted outside idle");

endmodule
